>>> rtl/cc8_pkg.sv
// ----------------------------------------------------------------------------
// cc8_pkg: shared types and constants for the ChaCha8 stream cipher
// Holds the constant rows, register indexes, queue item type and the
// quarter-round / double-round helper functions.
// ----------------------------------------------------------------------------
package cc8_pkg;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAw     = $clog2(QDepth);
  localparam int unsigned NumDr   = 4;
  localparam int unsigned DrCntW  = $clog2(NumDr + 1);

  typedef enum logic [2:0] {
    REG_KEY01  = 3'd0,
    REG_KEY23  = 3'd1,
    REG_KEY45  = 3'd2,
    REG_KEY67  = 3'd3,
    REG_LONG   = 3'd4,
    REG_NONCE  = 3'd5
  } reg_idx_e;

  localparam logic [31:0] ConstLong  [4] = '{32'h61707865, 32'h3320646e,
                                              32'h79622d32, 32'h6b206574};
  localparam logic [31:0] ConstShort [4] = '{32'h61707865, 32'h3120646e,
                                              32'h79622d36, 32'h6b206574};

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  // One accepted item, classified by the front end.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        msg_end;
    logic [7:0]  mask;      // valid bytes
    logic [2:0]  lane;      // 8-byte lane of the block
    logic        new_blk;   // item needs a fresh block
  } item_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t qr(input state_t s, input int unsigned a,
                                input int unsigned b, input int unsigned c,
                                input int unsigned d);
    state_t t;
    t = s;
    t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 16);
    t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 12);
    t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 8);
    t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 7);
    qr = t;
  endfunction

  function automatic state_t double_round(input state_t s);
    state_t t;
    t = qr(s, 0, 4, 8, 12);
    t = qr(t, 1, 5, 9, 13);
    t = qr(t, 2, 6, 10, 14);
    t = qr(t, 3, 7, 11, 15);
    t = qr(t, 0, 5, 10, 15);
    t = qr(t, 1, 6, 11, 12);
    t = qr(t, 2, 7, 8, 13);
    t = qr(t, 3, 4, 9, 14);
    double_round = t;
  endfunction

endpackage

>>> rtl/cc8_front.sv
// ----------------------------------------------------------------------------
// cc8_front: item classifier
// Tracks lane position and marks which items start a fresh keystream block.
// ----------------------------------------------------------------------------
module cc8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [63:0]       data_i,
  input  logic [3:0]        count_i,
  input  logic              end_i,
  input  logic              flush_i,
  output cc8_pkg::item_t    item_o
);

  logic       held_q, held_d;
  logic [2:0] lane_q, lane_d;
  logic       full8;
  logic [7:0] mask;

  assign full8 = (count_i >= 4'd8);

  always_comb begin
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      mask[i] = full8 || (4'(i) < count_i);
    end
  end

  always_comb begin
    item_o.data    = data_i;
    item_o.count   = count_i;
    item_o.msg_end = end_i;
    item_o.mask    = mask;
    item_o.lane    = held_q ? lane_q : 3'd0;
    item_o.new_blk = !held_q;
  end

  always_comb begin
    held_d = held_q;
    lane_d = lane_q;
    if (in_valid_i && in_ready_i) begin
      if (item_o.lane == 3'd7 || end_i || !full8) begin
        held_d = 1'b0;
        lane_d = 3'd0;
      end else begin
        held_d = 1'b1;
        lane_d = item_o.lane + 3'd1;
      end
    end
    if (flush_i) begin
      held_d = 1'b0;
      lane_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      lane_q <= 3'd0;
    end else begin
      held_q <= held_d;
      lane_q <= lane_d;
    end
  end

endmodule

>>> rtl/cc8_queue.sv
// ----------------------------------------------------------------------------
// cc8_queue: item queue between front and back
// Small FIFO of classified items.
// ----------------------------------------------------------------------------
module cc8_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  cc8_pkg::item_t    wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output cc8_pkg::item_t    rdata_o,
  output logic              empty_o
);

  cc8_pkg::item_t mem_q [cc8_pkg::QDepth];
  logic [cc8_pkg::QAw-1:0] wp_q, rp_q;
  logic [cc8_pkg::QAw:0]   cnt_q;

  assign full_o  = (cnt_q == (cc8_pkg::QAw+1)'(cc8_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (cc8_pkg::QAw+1)'(wr_i) - (cc8_pkg::QAw+1)'(rd_i);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i) else $error("queue write while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !rd_i) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (cc8_pkg::QAw+1)'(cc8_pkg::QDepth)) else $error("queue count out of range");
`endif

endmodule

>>> rtl/cc8_back.sv
// ----------------------------------------------------------------------------
// cc8_back: keystream core and output stage
// Runs one double round per cycle, adds the input state, XORs the lane.
// ----------------------------------------------------------------------------
module cc8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [63:0]       key01_i,
  input  logic [63:0]       key23_i,
  input  logic [63:0]       key45_i,
  input  logic [63:0]       key67_i,
  input  logic              long_i,
  input  logic [63:0]       nonce_i,
  input  logic              ctr_clr_i,
  input  logic              q_empty_i,
  input  cc8_pkg::item_t    q_item_i,
  output logic              q_pop_o,
  output logic              out_empty_o,
  input  logic              out_pop_i,
  output logic [63:0]       out_data_o,
  output logic [3:0]        out_count_o,
  output logic              out_end_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } st_e;

  st_e st_q, st_d;
  logic [cc8_pkg::DrCntW-1:0] dr_q;
  logic [63:0]          ctr_q;
  cc8_pkg::state_t      init_q, work_q, ks_q, init_c;
  logic                 out_v_q;
  logic [63:0]          out_data_q;
  logic [3:0]           out_count_q;
  logic                 out_end_q;
  logic                 out_free, can_go;
  logic [63:0]          ks_lane;
  cc8_pkg::state_t      fin_ks;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_c[i] = long_i ? cc8_pkg::ConstLong[i] : cc8_pkg::ConstShort[i];
    end
    init_c[4]  = key01_i[31:0];  init_c[5]  = key01_i[63:32];
    init_c[6]  = key23_i[31:0];  init_c[7]  = key23_i[63:32];
    init_c[8]  = long_i ? key45_i[31:0]  : key01_i[31:0];
    init_c[9]  = long_i ? key45_i[63:32] : key01_i[63:32];
    init_c[10] = long_i ? key67_i[31:0]  : key23_i[31:0];
    init_c[11] = long_i ? key67_i[63:32] : key23_i[63:32];
    init_c[12] = ctr_q[31:0];    init_c[13] = ctr_q[63:32];
    init_c[14] = nonce_i[31:0];  init_c[15] = nonce_i[63:32];
  end

  assign out_free = !out_v_q || out_pop_i;
  assign can_go   = (st_q == ST_IDLE) && !q_empty_i && !q_item_i.new_blk && out_free;
  assign q_pop_o  = can_go || ((st_q == ST_FIN) && out_free);
  assign ks_lane  = {ks_q[{q_item_i.lane, 1'b1}], ks_q[{q_item_i.lane, 1'b0}]};

  always_comb begin
    for (int i = 0; i < 16; i++) fin_ks[i] = work_q[i] + init_q[i];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (!q_empty_i && q_item_i.new_blk) st_d = ST_RUN;
      ST_RUN:  if (dr_q == cc8_pkg::DrCntW'(cc8_pkg::NumDr - 1)) st_d = ST_FIN;
      ST_FIN:  if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      dr_q    <= '0;
      ctr_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_IDLE) dr_q <= '0;
      else if (st_q == ST_RUN) dr_q <= dr_q + 1'b1;
      if (ctr_clr_i) ctr_q <= '0;
      else if (st_q == ST_IDLE && st_d == ST_RUN) ctr_q <= ctr_q + 64'd1;
      if (q_pop_o) out_v_q <= 1'b1;
      else if (out_pop_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE) begin
      init_q <= init_c;
      work_q <= init_c;
    end else if (st_q == ST_RUN) begin
      work_q <= cc8_pkg::double_round(work_q);
    end
    if (st_q == ST_FIN) ks_q <= fin_ks;
    if (q_pop_o) begin
      for (int b = 0; b < 8; b++) begin
        out_data_q[8*b +: 8] <= q_item_i.mask[b]
          ? (q_item_i.data[8*b +: 8] ^
             ((st_q == ST_FIN) ? fin_ks[{q_item_i.lane, 1'(b/4)}][8*(b%4) +: 8]
                               : ks_lane[8*b +: 8]))
          : 8'h00;
      end
      out_count_q <= q_item_i.count;
      out_end_q   <= q_item_i.msg_end;
    end
  end

  assign out_empty_o = !out_v_q;
  assign out_data_o  = out_data_q;
  assign out_count_o = out_count_q;
  assign out_end_o   = out_end_q;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i) else $error("pop from empty queue");
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> (dr_q < cc8_pkg::DrCntW'(cc8_pkg::NumDr))) else $error("round count");
  a_fin_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN) |-> $past(st_q == ST_RUN || st_q == ST_FIN))
    else $error("finish without rounds");
`endif

endmodule

>>> rtl/chacha8_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha8_stream_cipher: ChaCha8 stream cipher, 8 bytes per item
// XORs message bytes with ChaCha8 keystream; encrypt and decrypt alike.
// ----------------------------------------------------------------------------
// Channel | Ports                                   | Handshake
// input   | message_data_i, byte_count_i, message_end_i | push / full
// result  | cipher_data_o, out_byte_count_o, out_message_end_o | empty / pop
// config  | cfg_we_i, cfg_idx_i, cfg_wdata_i        | write on cfg_we_i
//
// An item reusing a held block goes from queue into a free output register.
// An item that opens a block waits for the round core: a setup step, four
// double rounds (one a cycle) and a final add.
// Reset clears counter, lane position, queue and output stage.
// Full rises when the four-entry item queue fills; the output register
// holds its item until popped while the queue keeps taking items.
// ----------------------------------------------------------------------------
module chacha8_stream_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] message_data_i,
  input  logic [3:0]  byte_count_i,
  input  logic        message_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] cipher_data_o,
  output logic [3:0]  out_byte_count_o,
  output logic        out_message_end_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce_q;
  logic        long_q;
  logic        nonce_wr, q_full, q_empty, q_pop, push_ok;
  cc8_pkg::item_t fr_item, q_item;

  assign nonce_wr = cfg_we_i && (cfg_idx_i == cc8_pkg::REG_NONCE);
  assign full     = q_full;
  assign push_ok  = push && !q_full;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q <= '0;
      key23_q <= '0;
      key45_q <= '0;
      key67_q <= '0;
      long_q  <= 1'b1;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cc8_pkg::REG_KEY01: key01_q <= cfg_wdata_i;
        cc8_pkg::REG_KEY23: key23_q <= cfg_wdata_i;
        cc8_pkg::REG_KEY45: key45_q <= cfg_wdata_i;
        cc8_pkg::REG_KEY67: key67_q <= cfg_wdata_i;
        cc8_pkg::REG_LONG:  long_q  <= cfg_wdata_i[0];
        cc8_pkg::REG_NONCE: nonce_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cc8_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (push),
    .in_ready_i (!q_full),
    .data_i     (message_data_i),
    .count_i    (byte_count_i),
    .end_i      (message_end_i),
    .flush_i    (nonce_wr),
    .item_o     (fr_item)
  );

  cc8_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i    (push_ok),
    .wdata_i (fr_item),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (q_item),
    .empty_o (q_empty)
  );

  cc8_back u_back (
    .clk_i, .rst_ni,
    .key01_i (key01_q), .key23_i (key23_q), .key45_i (key45_q),
    .key67_i (key67_q), .long_i (long_q), .nonce_i (nonce_q),
    .ctr_clr_i   (nonce_wr),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .out_data_o  (cipher_data_o),
    .out_count_o (out_byte_count_o),
    .out_end_o   (out_message_end_o)
  );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ChaCha8 stream cipher
// Drives message items through the push/full side, pops results at random,
// and compares every result with an in-bench ChaCha8 keystream predictor
// that tracks key, mode, nonce, block counter and lane position.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        msg_end;
  } cipher_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [63:0] message_data_i;
  logic [3:0]  byte_count_i;
  logic        message_end_i;
  logic        empty;
  logic        pop;
  logic [63:0] cipher_data_o;
  logic [3:0]  out_byte_count_o;
  logic        out_message_end_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  chacha8_stream_cipher i_dut (.*);

  // Predictor state, kept apart from the block.
  logic [63:0] key_lo01, key_lo23, key_hi45, key_hi67, nonce_reg, blk_ctr;
  logic        long_key;
  logic [31:0] ks_words [16];
  logic [2:0]  lane_pos;
  logic        ks_held;

  cipher_item_t expected_cipher_q [$];
  int unsigned  errors;
  int unsigned  results_seen;
  int unsigned  cycle_cnt;
  int unsigned  items_sent;
  bit           pop_quiet;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Apply one quarter round in place on the working words.
  task automatic quarter(inout logic [31:0] w [16], input int a, b, c, d);
    w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
  endtask

  // Compute the next keystream block and advance the counter.
  task automatic gen_keystream_block();
    logic [31:0] init [16];
    logic [31:0] w [16];
    logic [63:0] hi0, hi1;
    hi0 = long_key ? key_hi45 : key_lo01;
    hi1 = long_key ? key_hi67 : key_lo23;
    for (int i = 0; i < 4; i++) begin
      init[i] = long_key ? cc8_pkg::ConstLong[i] : cc8_pkg::ConstShort[i];
    end
    init[4]  = key_lo01[31:0];  init[5]  = key_lo01[63:32];
    init[6]  = key_lo23[31:0];  init[7]  = key_lo23[63:32];
    init[8]  = hi0[31:0];       init[9]  = hi0[63:32];
    init[10] = hi1[31:0];       init[11] = hi1[63:32];
    init[12] = blk_ctr[31:0];   init[13] = blk_ctr[63:32];
    init[14] = nonce_reg[31:0]; init[15] = nonce_reg[63:32];
    w = init;
    for (int r = 0; r < 4; r++) begin
      quarter(w, 0, 4, 8, 12);  quarter(w, 1, 5, 9, 13);
      quarter(w, 2, 6, 10, 14); quarter(w, 3, 7, 11, 15);
      quarter(w, 0, 5, 10, 15); quarter(w, 1, 6, 11, 12);
      quarter(w, 2, 7, 8, 13);  quarter(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
    blk_ctr  = blk_ctr + 64'd1;
    ks_held  = 1'b1;
    lane_pos = 3'd0;
  endtask

  task automatic predict_cipher(input cipher_item_t it);
    cipher_item_t res;
    logic [63:0]  ks, mask;
    int unsigned  n;
    n = (it.count > 8) ? 8 : it.count;
    if (!ks_held) gen_keystream_block();
    ks   = {ks_words[2 * lane_pos + 1], ks_words[2 * lane_pos]};
    mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    res.data    = (it.data ^ ks) & mask;
    res.count   = it.count;
    res.msg_end = it.msg_end;
    expected_cipher_q.push_back(res);
    if (lane_pos == 3'd7 || it.msg_end || n < 8) begin
      ks_held  = 1'b0;
      lane_pos = 3'd0;
    end else begin
      lane_pos = lane_pos + 3'd1;
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one item; the predictor runs at the accepting edge.
  task automatic send_item(input logic [63:0] d, input logic [3:0] c, input logic e);
    cipher_item_t it;
    it = '{data: d, count: c, msg_end: e};
    message_data_i <= d;
    byte_count_i   <= c;
    message_end_i  <= e;
    push           <= 1'b1;
    do @(posedge clk_i); while (full);
    predict_cipher(it);
    items_sent++;
    repeat (gap_len()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_cipher_q.size() != 0) @(posedge clk_i);
    // Let any in-flight block computation settle.
    repeat (12) @(posedge clk_i);
  endtask

  // Write one register; callers hold the block idle first.
  task automatic write_reg(input cc8_pkg::reg_idx_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cc8_pkg::REG_KEY01: key_lo01 = val;
      cc8_pkg::REG_KEY23: key_lo23 = val;
      cc8_pkg::REG_KEY45: key_hi45 = val;
      cc8_pkg::REG_KEY67: key_hi67 = val;
      cc8_pkg::REG_LONG:  long_key = val[0];
      cc8_pkg::REG_NONCE: begin
        nonce_reg = val;
        blk_ctr   = '0;
        ks_held   = 1'b0;
        lane_pos  = 3'd0;
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Pop side: random stalls, compare each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_cipher_q.size() == 0) begin
          $error("unexpected result data=%h", cipher_data_o);
          errors++;
        end else begin
          cipher_item_t exp_r;
          exp_r = expected_cipher_q.pop_front();
          results_seen++;
          if (cipher_data_o !== exp_r.data) begin
            $error("cipher_data exp %h got %h", exp_r.data, cipher_data_o);
            errors++;
          end
          if (out_byte_count_o !== exp_r.count) begin
            $error("out_byte_count exp %0d got %0d", exp_r.count, out_byte_count_o);
            errors++;
          end
          if (out_message_end_o !== exp_r.msg_end) begin
            $error("out_message_end exp %0d got %0d", exp_r.msg_end, out_message_end_o);
            errors++;
          end
        end
      end
      pop <= pop_quiet ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
  end

  // Watchdog: generous bound over the slowest correct run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Directed: field extremes, every byte count, message end, block wrap.
  task automatic test_directed();
    write_reg(cc8_pkg::REG_KEY01, 64'h0706050403020100);
    write_reg(cc8_pkg::REG_KEY23, 64'h0f0e0d0c0b0a0908);
    write_reg(cc8_pkg::REG_KEY45, 64'h1716151413121110);
    write_reg(cc8_pkg::REG_KEY67, 64'h1f1e1d1c1b1a1918);
    write_reg(cc8_pkg::REG_NONCE, 64'h0000004a00000000);
    for (int i = 0; i < 9; i++) send_item(64'h0, 4'd8, 1'b0);  // wrap past lane 7
    send_item('1, 4'd8, 1'b1);
    for (int c = 0; c <= 15; c++) send_item(rand64(), c[3:0], 1'b0);
    drain();
  endtask

  // Short-key mode and the all-ones key extremes.
  task automatic test_short_key();
    write_reg(cc8_pkg::REG_LONG, 64'd0);
    write_reg(cc8_pkg::REG_KEY01, '1);
    write_reg(cc8_pkg::REG_KEY23, '1);
    write_reg(cc8_pkg::REG_NONCE, '1);
    for (int i = 0; i < 20; i++) send_item(rand64(), 4'd8, i % 7 == 6);
    drain();
    write_reg(cc8_pkg::REG_LONG, 64'd1);
  endtask

  // Key write with a block held: the held block stays in use.
  task automatic test_key_midblock();
    send_item(rand64(), 4'd8, 1'b0);
    send_item(rand64(), 4'd8, 1'b0);
    drain();
    write_reg(cc8_pkg::REG_KEY01, rand64());
    for (int i = 0; i < 8; i++) send_item(rand64(), 4'd8, 1'b0);
    drain();
  endtask

  // Random messages: mostly full 8-byte runs, some short tails and noise.
  task automatic test_random(input int unsigned n_items);
    int unsigned k;
    k = 0;
    while (k < n_items) begin
      int unsigned len;
      len = $urandom_range(1, 20);
      for (int j = 0; j < len && k < n_items; j++, k++) begin
        logic [3:0] c;
        c = ($urandom_range(0, 9) < 8) ? 4'd8 : 4'($urandom_range(0, 15));
        send_item(rand64(), c, (j == len - 1) ? 1'b1 : ($urandom_range(0, 30) == 0));
      end
      if ($urandom_range(0, 40) == 0) begin
        drain();
        write_reg(cc8_pkg::reg_idx_e'($urandom_range(0, 5)), rand64());
      end
    end
    drain();
  endtask

  // Counter restart after a nonce write, with pops always on, then random pops.
  task automatic test_phases();
    write_reg(cc8_pkg::REG_KEY45, '0);
    write_reg(cc8_pkg::REG_KEY67, '1);
    write_reg(cc8_pkg::REG_NONCE, '0);
    pop_quiet = 1'b1;
    for (int i = 0; i < 24; i++) send_item(rand64(), 4'd8, 1'b0);
    drain();  // sender holds until every result is back
    pop_quiet = 1'b0;
    for (int i = 0; i < 24; i++) send_item(rand64(), 4'd8, 1'b0);
    drain();
  endtask

  initial begin
    errors = 0; results_seen = 0; cycle_cnt = 0; items_sent = 0; pop_quiet = 1'b0;
    key_lo01 = '0; key_lo23 = '0; key_hi45 = '0; key_hi67 = '0;
    nonce_reg = '0; blk_ctr = '0; long_key = 1'b1; ks_held = 1'b0; lane_pos = '0;
    rst_ni = 1'b0; push = 1'b0; pop = 1'b0;
    message_data_i = '0; byte_count_i = '0; message_end_i = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = cc8_pkg::REG_KEY01; cfg_wdata_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_short_key();
    test_key_midblock();
    test_phases();
    test_random(850);
    $display("Ran %0d items through key/mode/nonce changes, got %0d results.",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
